[hw/rtl/sfx_pkg.sv]
// ----------------------------------------------------------------------------
// sfx_pkg: shared types and constants
// Frame geometry, status codes and stage records for the SPI frame exchanger.
// ----------------------------------------------------------------------------
`default_nettype none

package sfx_pkg;

  // frame geometry
  localparam int FRAME_LENGTH   = 18;
  localparam int BUFFER_DEPTH   = FRAME_LENGTH - 1;
  localparam int WORD_COUNT     = 8;
  localparam int FEEDBACK_COUNT = 6;
  localparam int DECODE_FIRST   = 2;
  localparam int DECODE_LAST    = DECODE_FIRST + 2 * FEEDBACK_COUNT - 1;

  localparam int COUNT_W = $clog2(FRAME_LENGTH);
  localparam int WIDX_W  = $clog2(WORD_COUNT);
  localparam int FBIDX_W = $clog2(FEEDBACK_COUNT);

  localparam logic [7:0] END_MARKER = 8'hAA;

  // per-transaction status reported on the result channel
  typedef enum logic [1:0] {
    ST_COLLECTING = 2'd0,
    ST_COMPLETE   = 2'd1,
    ST_EARLY      = 2'd2,
    ST_MISSING    = 2'd3
  } frame_status_t;

  typedef logic [FEEDBACK_COUNT-1:0][15:0] feedback_t;

  // reply selection carried alongside the command memory read
  typedef struct packed {
    frame_status_t status;
    logic          lo_byte;
    logic          marker;
  } step_t;

endpackage

`default_nettype wire

[hw/rtl/sfx_rx_if.sv]
// ----------------------------------------------------------------------------
// sfx_rx_if: receive byte channel
// Valid/ready channel carrying one byte received from the SPI master.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfx_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/sfx_tx_if.sv]
// ----------------------------------------------------------------------------
// sfx_tx_if: result channel
// Valid/ready channel carrying the reply byte, frame status and feedback.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfx_tx_if;
  logic        valid;
  logic        ready;
  logic [7:0]  tx_byte;
  logic [1:0]  frame_status;
  logic [15:0] roll_attitude;
  logic [15:0] pitch_attitude;
  logic [15:0] yaw_attitude;
  logic [15:0] roll_rate;
  logic [15:0] pitch_rate;
  logic [15:0] yaw_rate;

  modport source (output valid, output tx_byte, output frame_status,
                  output roll_attitude, output pitch_attitude, output yaw_attitude,
                  output roll_rate, output pitch_rate, output yaw_rate,
                  input ready);
  modport sink   (input valid, input tx_byte, input frame_status,
                  input roll_attitude, input pitch_attitude, input yaw_attitude,
                  input roll_rate, input pitch_rate, input yaw_rate,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/spi_frame_exchange_with_end_marker.sv]
// ----------------------------------------------------------------------------
// spi_frame_exchange_with_end_marker: SPI slave frame exchanger
// Collects received bytes into frames closed by a double 0xAA end marker,
// decodes six feedback words and returns the command frame reply byte.
//
//   channel  dir  handshake       payload
//   rx       in   valid / ready   rx_byte
//   tx       out  valid / ready   tx_byte, frame_status, six feedback words
//   cfg      in   cfg_we          cfg_index, cfg_data (command words 0..7)
//
// One transaction per clock while tx is not stalled; the result goes
// through the registered command memory read and the output register.
// Reset (synchronous) clears count, marker flag, feedback words and the
// command written flags (words read as zero). A stalled tx holds the
// result; rx keeps accepting until the read stage and output register are both full.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_frame_exchange_with_end_marker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [sfx_pkg::WIDX_W-1:0] cfg_index,
  input  wire logic [15:0]                cfg_data,
  sfx_rx_if.sink                          rx,
  sfx_tx_if.source                        tx
);

  logic               in_fire;
  logic               s1_adv;
  logic               s1_valid;
  sfx_pkg::step_t     step;
  sfx_pkg::step_t     s1_step;
  sfx_pkg::feedback_t feedback_next;
  sfx_pkg::feedback_t s1_fb;
  logic [sfx_pkg::WIDX_W-1:0] rd_addr;
  logic [15:0]        rd_data;
  logic [7:0]         reply;
  logic               out_valid;
  logic [7:0]         out_byte;
  sfx_pkg::frame_status_t out_status;
  sfx_pkg::feedback_t out_fb;

  // handshake
  assign s1_adv   = !out_valid || tx.ready;
  assign rx.ready = !s1_valid || s1_adv;
  assign in_fire  = rx.valid && rx.ready;

  sfx_framer u_framer (
    .clk           (clk),
    .rst           (rst),
    .fire          (in_fire),
    .rx_byte       (rx.rx_byte),
    .step          (step),
    .rd_addr       (rd_addr),
    .feedback_next (feedback_next)
  );

  sfx_cmd_mem u_cmd_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg_we),
    .wr_addr (cfg_index),
    .wr_data (cfg_data),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // read stage: waits for the command word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_step <= step;
      s1_fb   <= feedback_next;
    end
  end

  // reply byte: marker tail or one half of the command word
  always_comb begin
    if (s1_step.marker) begin
      reply = sfx_pkg::END_MARKER;
    end else if (s1_step.lo_byte) begin
      reply = rd_data[7:0];
    end else begin
      reply = rd_data[15:8];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_byte   <= reply;
      out_status <= s1_step.status;
      out_fb     <= s1_fb;
    end
  end

  assign tx.valid          = out_valid;
  assign tx.tx_byte        = out_byte;
  assign tx.frame_status   = out_status;
  assign tx.roll_attitude  = out_fb[0];
  assign tx.pitch_attitude = out_fb[1];
  assign tx.yaw_attitude   = out_fb[2];
  assign tx.roll_rate      = out_fb[3];
  assign tx.pitch_rate     = out_fb[4];
  assign tx.yaw_rate       = out_fb[5];

endmodule

`default_nettype wire

[hw/rtl/sfx_cmd_mem.sv]
// ----------------------------------------------------------------------------
// sfx_cmd_mem: command word memory
// Eight 16-bit command words, written by the configuration port and read
// through a register. Unwritten words read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sfx_cmd_mem (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      wr_en,
  input  wire logic [sfx_pkg::WIDX_W-1:0] wr_addr,
  input  wire logic [15:0]               wr_data,
  input  wire logic                      rd_en,
  input  wire logic [sfx_pkg::WIDX_W-1:0] rd_addr,
  output      logic [15:0]               rd_data
);

  logic [15:0]                     words [sfx_pkg::WORD_COUNT];
  logic [sfx_pkg::WORD_COUNT-1:0]  written;

  // per-word written flags, cleared by reset so words read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      words[wr_addr] <= wr_data;
    end
  end

  // registered read, held while no new read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= written[rd_addr] ? words[rd_addr] : 16'h0000;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sfx_framer.sv]
// ----------------------------------------------------------------------------
// sfx_framer: receive framing
// Byte count, end marker detection, capture of the feedback bytes and the
// decoded feedback words. Works out the reply index for each transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module sfx_framer (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       fire,
  input  wire logic [7:0]                 rx_byte,
  output      sfx_pkg::step_t             step,
  output      logic [sfx_pkg::WIDX_W-1:0] rd_addr,
  output      sfx_pkg::feedback_t         feedback_next
);

  logic [sfx_pkg::COUNT_W-1:0] count;
  logic [sfx_pkg::COUNT_W-1:0] count_next;
  logic                        prev_marker;
  logic                        prev_marker_next;
  logic                        is_end;
  logic                        full;
  logic                        capture;
  logic [sfx_pkg::COUNT_W-1:0] dec_off;
  logic [15:0]                 staging [sfx_pkg::FEEDBACK_COUNT];
  sfx_pkg::feedback_t          feedback;
  sfx_pkg::feedback_t          staged;

  // marker pairing and frame decision
  always_comb begin
    is_end           = (rx_byte == sfx_pkg::END_MARKER) && prev_marker;
    prev_marker_next = (rx_byte == sfx_pkg::END_MARKER) && !prev_marker;
    full             = count >= sfx_pkg::COUNT_W'(sfx_pkg::BUFFER_DEPTH);
    priority if (!full && !is_end) begin
      step.status = sfx_pkg::ST_COLLECTING;
      count_next  = count + sfx_pkg::COUNT_W'(1);
    end else if (full && is_end) begin
      step.status = sfx_pkg::ST_COMPLETE;
      count_next  = '0;
    end else if (is_end) begin
      step.status = sfx_pkg::ST_EARLY;
      count_next  = '0;
    end else begin
      step.status = sfx_pkg::ST_MISSING;
      count_next  = '0;
    end
    step.lo_byte = count_next[0];
    step.marker  = count_next >= sfx_pkg::COUNT_W'(2 * sfx_pkg::WORD_COUNT);
    rd_addr      = count_next[sfx_pkg::WIDX_W:1];
  end

  // bytes of the feedback words are caught as they arrive
  always_comb begin
    dec_off = count - sfx_pkg::COUNT_W'(sfx_pkg::DECODE_FIRST);
    capture = (step.status == sfx_pkg::ST_COLLECTING)
           && (count >= sfx_pkg::COUNT_W'(sfx_pkg::DECODE_FIRST))
           && (count <= sfx_pkg::COUNT_W'(sfx_pkg::DECODE_LAST));
    for (int k = 0; k < sfx_pkg::FEEDBACK_COUNT; k++) begin
      staged[k] = staging[k];
    end
    feedback_next = (step.status == sfx_pkg::ST_COMPLETE) ? staged : feedback;
  end

  // count and marker flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      prev_marker <= 1'b0;
    end else if (fire) begin
      count       <= count_next;
      prev_marker <= prev_marker_next;
    end
  end

  // staging words, high byte at even offset
  always_ff @(posedge clk) begin
    if (fire && capture) begin
      if (dec_off[0]) begin
        staging[dec_off[sfx_pkg::FBIDX_W:1]][7:0]  <= rx_byte;
      end else begin
        staging[dec_off[sfx_pkg::FBIDX_W:1]][15:8] <= rx_byte;
      end
    end
  end

  // decoded feedback words
  always_ff @(posedge clk) begin
    if (rst) begin
      feedback <= '0;
    end else if (fire) begin
      feedback <= feedback_next;
    end
  end

endmodule

`default_nettype wire
